// ----- design/hmr_pkg.sv -----
`timescale 1ns / 1ps

package hmr_pkg;

  // Default configuration
  localparam int LEVELS_DEF        = 256;
  localparam int CDF_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int ACT_W = 2;
  localparam int IDX_W = 8;
  localparam int CDF_W = 17;
  localparam int PIX_W = 8;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD_SRC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_REF = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BUILD    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_MAP      = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] level_index;
    logic [CDF_W-1:0] cdf_value;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             map_ready;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_src;    // write quantized cdf into source table
    logic load_ref;    // write quantized cdf into reference table
    logic map_rd;      // read level map at the incoming pixel
    logic build_init;  // clear source level counter and previous map value
    logic src_rd;      // read source table at current level
    logic ref_first;   // start reference scan at level zero
    logic ref_next;    // advance reference scan
    logic map_wr;      // write map entry for current source level
    logic next_i;      // advance source level
    logic out_load;    // capture a result into the output register
    logic out_map;     // result carries the looked-up pixel
    logic out_flag;    // map_ready bit of the result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_stop;   // reference scan found its level or hit the end
    logic last_i;      // current source level is the top one
  } dp_stat_t;

endpackage

// ----- design/hmr_ram.sv -----
`timescale 1ns / 1ps

module hmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/hmr_ctrl.sv -----
`timescale 1ns / 1ps

module hmr_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [hmr_pkg::ACT_W-1:0] action,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  hmr_pkg::dp_stat_t        stat,
  output hmr_pkg::dp_cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_MAP_WAIT  = 3'd1;
  localparam logic [2:0] ST_SRC_RD    = 3'd2;
  localparam logic [2:0] ST_SCAN      = 3'd3;
  localparam logic [2:0] ST_BUILD_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       built_r, built_nxt;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    built_nxt = built_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (action)
            hmr_pkg::ACT_LOAD_SRC, hmr_pkg::ACT_LOAD_REF: begin
              cmd.load_src = (action == hmr_pkg::ACT_LOAD_SRC);
              cmd.load_ref = (action == hmr_pkg::ACT_LOAD_REF);
              cmd.out_load = 1'b1;
              cmd.out_flag = 1'b0;
              built_nxt    = 1'b0;
            end
            hmr_pkg::ACT_BUILD: begin
              cmd.build_init = 1'b1;
              state_nxt      = ST_SRC_RD;
            end
            default: begin
              cmd.map_rd = 1'b1;
              state_nxt  = ST_MAP_WAIT;
            end
          endcase
        end
      end
      ST_MAP_WAIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_map  = 1'b1;
          cmd.out_flag = built_r;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SRC_RD: begin
        cmd.src_rd    = 1'b1;
        cmd.ref_first = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_stop) begin
          cmd.map_wr = 1'b1;
          if (stat.last_i) begin
            state_nxt = ST_BUILD_OUT;
          end else begin
            cmd.next_i = 1'b1;
            state_nxt  = ST_SRC_RD;
          end
        end else begin
          cmd.ref_next = 1'b1;
        end
      end
      ST_BUILD_OUT: begin
        built_nxt = 1'b1;
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_flag = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      built_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      built_r     <= built_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/hmr_dpath.sv -----
`timescale 1ns / 1ps

module hmr_dpath #(
  parameter int LEVELS        = hmr_pkg::LEVELS_DEF,
  parameter int CDF_FRAC_BITS = hmr_pkg::CDF_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  hmr_pkg::in_item_t  in_item,
  input  hmr_pkg::dp_cmd_t   cmd,
  output hmr_pkg::dp_stat_t  stat,
  output hmr_pkg::out_item_t out_item
);

  localparam int LVL_W = $clog2(LEVELS);
  localparam int PRD_W = LVL_W + hmr_pkg::CDF_W;
  localparam int CMP_W = LVL_W + hmr_pkg::IDX_W + 1;
  localparam logic [LVL_W-1:0] TOP = LVL_W'(LEVELS - 1);

  logic [LVL_W-1:0]   i_r, i_nxt;
  logic [LVL_W-1:0]   j_r, j_nxt;
  logic [LVL_W:0]     p1_r, p1_nxt;     // previous map value plus one
  hmr_pkg::out_item_t out_r;

  logic [PRD_W-1:0]   prod, q_full;
  logic [LVL_W-1:0]   q;
  logic               idx_ok;
  logic [LVL_W-1:0]   load_addr;
  logic [LVL_W-1:0]   pix_addr;
  logic [LVL_W-1:0]   src_rdata, ref_rdata, map_rdata;
  logic [LVL_W-1:0]   ref_raddr;
  logic [LVL_W-1:0]   jm1;
  logic [LVL_W-1:0]   m;

  // Quantize the cdf entry: floor((LEVELS-1) * cdf), saturated
  assign prod   = PRD_W'(LEVELS - 1) * PRD_W'(in_item.cdf_value);
  assign q_full = prod >> CDF_FRAC_BITS;
  assign q      = (q_full > PRD_W'(LEVELS - 1)) ? TOP : LVL_W'(q_full);

  // Load address range check and pixel saturation
  assign idx_ok    = CMP_W'(in_item.level_index) < CMP_W'(LEVELS);
  assign load_addr = LVL_W'(in_item.level_index);
  assign pix_addr  = (CMP_W'(in_item.pixel_in) < CMP_W'(LEVELS)) ?
                     LVL_W'(in_item.pixel_in) : TOP;

  // Reference scan address: zero at the start of a level, else the next one
  assign ref_raddr = cmd.ref_first ? '0 : LVL_W'(j_r + 1'b1);

  hmr_ram #(.WIDTH(LVL_W), .DEPTH(LEVELS)) u_src_ram (
    .clk   (clk),
    .we    (cmd.load_src && idx_ok),
    .waddr (load_addr),
    .wdata (q),
    .re    (cmd.src_rd),
    .raddr (i_r),
    .rdata (src_rdata)
  );

  hmr_ram #(.WIDTH(LVL_W), .DEPTH(LEVELS)) u_ref_ram (
    .clk   (clk),
    .we    (cmd.load_ref && idx_ok),
    .waddr (load_addr),
    .wdata (q),
    .re    (cmd.ref_first || cmd.ref_next),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  hmr_ram #(.WIDTH(LVL_W), .DEPTH(LEVELS)) u_map_ram (
    .clk   (clk),
    .we    (cmd.map_wr),
    .waddr (i_r),
    .wdata (m),
    .re    (cmd.map_rd),
    .raddr (pix_addr),
    .rdata (map_rdata)
  );

  // Scan status: source value held in src_rdata, reference j in ref_rdata
  assign stat.scan_stop = (ref_rdata >= src_rdata) || (j_r == TOP);
  assign stat.last_i    = (i_r == TOP);

  // Map value for the current source level
  assign jm1 = LVL_W'(j_r - 1'b1);
  always_comb begin
    if (ref_rdata == src_rdata) begin
      m = j_r;
    end else if (ref_rdata > src_rdata) begin
      if (j_r == '0) begin
        m = '0;
      end else if (p1_r < {1'b0, jm1}) begin
        m = LVL_W'(p1_r);
      end else begin
        m = jm1;
      end
    end else begin
      m = TOP;
    end
  end

  // Build counters
  always_comb begin
    i_nxt  = i_r;
    j_nxt  = j_r;
    p1_nxt = p1_r;
    if (cmd.build_init) begin
      i_nxt  = '0;
      p1_nxt = '0;
    end
    if (cmd.next_i) begin
      i_nxt = LVL_W'(i_r + 1'b1);
    end
    if (cmd.ref_first || cmd.ref_next) begin
      j_nxt = ref_raddr;
    end
    if (cmd.map_wr) begin
      p1_nxt = (LVL_W + 1)'(m) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    p1_r <= p1_nxt;
    if (cmd.out_load) begin
      out_r.pixel_out <= cmd.out_map ? hmr_pkg::PIX_W'(map_rdata) : '0;
      out_r.map_ready <= cmd.out_flag;
    end
  end

  assign out_item = out_r;

endmodule

// ----- design/histogram_matching_remap_core.sv -----
`timescale 1ns / 1ps

// Histogram matching remap. Load actions quantize a source or reference cdf
// entry to floor((LEVELS-1)*cdf) and store it; loads stream at one item per
// clock while the output register is free or being taken. A map action reads
// the level map (registered RAM read, then the output register). A build walks
// every source level and scans the reference table from level zero until it
// meets a value at or above the source value or reaches the top level, one
// reference entry per clock through the reference table's read port; each
// source level takes a source read and then the scan. The tables need no
// clearing after reset; the block is ready at once. Every item gives exactly
// one result; a result that waits in the output register holds off the next
// item until it is taken.
module histogram_matching_remap_core #(
  parameter int LEVELS        = hmr_pkg::LEVELS_DEF,
  parameter int CDF_FRAC_BITS = hmr_pkg::CDF_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hmr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output hmr_pkg::out_item_t out_item
);

  hmr_pkg::dp_cmd_t  cmd;
  hmr_pkg::dp_stat_t stat;

  hmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (in_item.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hmr_dpath #(
    .LEVELS        (LEVELS),
    .CDF_FRAC_BITS (CDF_FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

// ----- design/hmr_checker.sv -----
`timescale 1ns / 1ps

module hmr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input hmr_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input hmr_pkg::out_item_t out_item
);

  // No result is shown right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Input is taken only when the output side can take the result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input ready while result blocked");

  // A load answers next cycle with a zero pixel and map not ready
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_item.action == hmr_pkg::ACT_LOAD_SRC || in_item.action == hmr_pkg::ACT_LOAD_REF)
    |=> out_valid && !out_item.map_ready && (out_item.pixel_out == '0))
    else $error("bad load result");

  // A map lookup blocks input for its read cycle
  a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.action == hmr_pkg::ACT_MAP) |=> !in_ready)
    else $error("input taken during map read");

endmodule

bind histogram_matching_remap_core hmr_checker u_hmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
